// ----- hdl/trcv_pkg.sv -----
// ----------------------------------------------------------------------------
// trcv_pkg
// Shared types and constants for the truncated running convolution core.
// ----------------------------------------------------------------------------
package trcv_pkg;

    // Fixed field widths.
    localparam int SAMPLE_W = 16;
    localparam int PROD_W   = 2 * SAMPLE_W;
    localparam int ACC_W    = 48;
    localparam int CFG_W    = 9;

    // Reset value of the truncation depth register.
    localparam logic [CFG_W-1:0] DEPTH_RST = 9'd256;

    // Saturation limits of the Q18.30 accumulator.
    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic signed [PROD_W-1:0]   t_prod;
    typedef logic signed [ACC_W-1:0]    t_acc;

    // Channel payloads.
    typedef struct packed {
        t_sample sample_a;
        t_sample sample_b;
    } t_in_item;

    typedef struct packed {
        t_acc conv_sum;
    } t_out_item;

    typedef struct packed {
        logic [CFG_W-1:0] truncation_depth;
    } t_cfg_item;

    // Control from the sequencer to the multiply-accumulate unit.
    typedef struct packed {
        logic clear;
        logic data_vld;
    } t_mac_ctl;

    // Status from the multiply-accumulate unit.
    typedef struct packed {
        logic pending;
    } t_mac_stat;

endpackage

// ----- hdl/trcv_stream_if.sv -----
// ----------------------------------------------------------------------------
// trcv_stream_if
// Valid/ready channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
interface trcv_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ----- hdl/trcv_store.sv -----
// ----------------------------------------------------------------------------
// trcv_store
// Kernel memory and history ring memory, each with one write port and one
// registered read port.
// ----------------------------------------------------------------------------
module trcv_store #(
    parameter int MAX_TAPS = 256,
    parameter int AW       = 8
) (
    input  logic              i_clk,
    input  logic              i_k_we,
    input  logic [AW-1:0]     i_k_waddr,
    input  trcv_pkg::t_sample i_k_wdata,
    input  logic [AW-1:0]     i_k_raddr,
    output trcv_pkg::t_sample o_k_rdata,
    input  logic              i_h_we,
    input  logic [AW-1:0]     i_h_waddr,
    input  trcv_pkg::t_sample i_h_wdata,
    input  logic [AW-1:0]     i_h_raddr,
    output trcv_pkg::t_sample o_h_rdata
);
    import trcv_pkg::*;

    t_sample r_kernel_mem [MAX_TAPS];
    t_sample r_hist_mem   [MAX_TAPS];
    t_sample r_k_rdata;
    t_sample r_h_rdata;

    // Kernel memory: first samples of stream A.
    always_ff @(posedge i_clk) begin
        if (i_k_we) begin
            r_kernel_mem[i_k_waddr] <= i_k_wdata;
        end
        r_k_rdata <= r_kernel_mem[i_k_raddr];
    end

    // History memory: ring of the newest stream B samples.
    always_ff @(posedge i_clk) begin
        if (i_h_we) begin
            r_hist_mem[i_h_waddr] <= i_h_wdata;
        end
        r_h_rdata <= r_hist_mem[i_h_raddr];
    end

    assign o_k_rdata = r_k_rdata;
    assign o_h_rdata = r_h_rdata;

endmodule

// ----- hdl/trcv_mac.sv -----
// ----------------------------------------------------------------------------
// trcv_mac
// Shared multiply-accumulate unit: a registered product stage followed by a
// saturating 48-bit accumulator.
// ----------------------------------------------------------------------------
module trcv_mac (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  trcv_pkg::t_mac_ctl  i_ctl,
    input  trcv_pkg::t_sample   i_k_smp,
    input  trcv_pkg::t_sample   i_h_smp,
    output trcv_pkg::t_acc      o_acc,
    output trcv_pkg::t_mac_stat o_stat
);
    import trcv_pkg::*;

    t_prod               r_prod;
    logic                r_prod_vld;
    t_acc                r_acc;
    logic signed [ACC_W:0] n_sum;
    t_acc                n_acc;

    // Product stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_vld <= 1'b0;
        end else begin
            r_prod_vld <= i_ctl.data_vld;
        end
        if (i_ctl.data_vld) begin
            r_prod <= t_prod'(i_k_smp) * t_prod'(i_h_smp);
        end
    end

    // Saturating add of the product to the running sum.
    always_comb begin
        n_sum = {r_acc[ACC_W-1], r_acc} + (ACC_W+1)'(r_prod);
        if (n_sum[ACC_W] != n_sum[ACC_W-1]) begin
            n_acc = n_sum[ACC_W] ? ACC_MIN : ACC_MAX;
        end else begin
            n_acc = n_sum[ACC_W-1:0];
        end
    end

    // Accumulator register, cleared at the start of each item.
    always_ff @(posedge i_clk) begin
        if (i_ctl.clear) begin
            r_acc <= '0;
        end else if (r_prod_vld) begin
            r_acc <= n_acc;
        end
    end

    assign o_acc          = r_acc;
    assign o_stat.pending = r_prod_vld;

endmodule

// ----- hdl/truncated_running_convolution_core.sv -----
// ----------------------------------------------------------------------------
// truncated_running_convolution_core
// Each accepted input transaction yields one sum of T products,
//   where T = min(samples taken, truncation depth, MAX_TAPS); the sum is 0 if T = 0.
// A new input is accepted only in the idle state, after the previous result
//   has moved to the output register; the single multiply-accumulate unit
//   reads one kernel and one history entry per cycle while the terms run.
// Reset: sample count, ring position and pipeline clear; depth returns to 256.
//   The memories are not cleared; only entries already written are read.
// ----------------------------------------------------------------------------
module truncated_running_convolution_core #(
    parameter int MAX_TAPS = 256
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    trcv_stream_if.sink          i_in,
    trcv_stream_if.source        o_out,
    trcv_stream_if.sink          i_cfg
);
    import trcv_pkg::*;

    localparam int AW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
    localparam int CW = $clog2(MAX_TAPS + 1);
    localparam int DW = (CW > CFG_W) ? CW : CFG_W;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_RUN   = 2'd1;
    localparam logic [1:0] S_DRAIN = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    logic [1:0]       r_state;
    logic [CW-1:0]    r_count;
    logic [AW-1:0]    r_head;
    logic [AW-1:0]    r_hptr;
    logic [CW-1:0]    r_k;
    logic [CW-1:0]    r_terms;
    logic [CFG_W-1:0] r_depth;
    logic             r_rd_vld;
    logic             r_out_vld;
    t_acc             r_out_data;

    logic             in_acc;
    logic             cnt_open;
    logic [AW-1:0]    n_head;
    logic [AW-1:0]    n_hptr;
    logic [CW-1:0]    n_avail;
    logic [DW-1:0]    n_depth;
    logic [CW-1:0]    n_terms;
    logic             out_load;
    t_sample          k_rdata;
    t_sample          h_rdata;
    t_acc             acc;
    t_mac_ctl         mac_ctl;
    t_mac_stat        mac_stat;

    // Handshakes.
    assign i_in.ready  = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign in_acc      = i_in.valid && i_in.ready;
    assign out_load    = (r_state == S_DONE) && (!r_out_vld || o_out.ready);

    // Term count for a new item: samples available, capped by the depth.
    always_comb begin
        cnt_open = (r_count < CW'(MAX_TAPS));
        n_head   = (r_head == AW'(MAX_TAPS - 1)) ? '0 : r_head + 1'b1;
        n_hptr   = (r_hptr == '0) ? AW'(MAX_TAPS - 1) : r_hptr - 1'b1;
        n_avail  = cnt_open ? r_count + 1'b1 : CW'(MAX_TAPS);
        n_depth  = (DW'(r_depth) > DW'(MAX_TAPS)) ? DW'(MAX_TAPS) : DW'(r_depth);
        n_terms  = (DW'(n_avail) < n_depth) ? n_avail : n_depth[CW-1:0];
    end

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth <= DEPTH_RST;
        end else if (i_cfg.valid && i_cfg.ready) begin
            r_depth <= i_cfg.payload.truncation_depth;
        end
    end

    // Sequencer: write the new samples, then read one term per cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_head   <= '0;
            r_hptr   <= '0;
            r_k      <= '0;
            r_terms  <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= (r_state == S_RUN);
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        if (cnt_open) begin
                            r_count <= r_count + 1'b1;
                        end
                        r_head  <= n_head;
                        r_hptr  <= n_head;
                        r_k     <= '0;
                        r_terms <= n_terms;
                        r_state <= (n_terms == '0) ? S_DONE : S_RUN;
                    end
                end
                S_RUN: begin
                    r_k    <= r_k + 1'b1;
                    r_hptr <= n_hptr;
                    if (r_k == r_terms - 1'b1) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    if (!r_rd_vld && !mac_stat.pending) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_load) begin
            r_out_vld <= 1'b1;
        end else if (o_out.ready) begin
            r_out_vld <= 1'b0;
        end
        if (out_load) begin
            r_out_data <= acc;
        end
    end

    assign o_out.valid            = r_out_vld;
    assign o_out.payload.conv_sum = r_out_data;

    // Sample memories.
    trcv_store #(
        .MAX_TAPS (MAX_TAPS),
        .AW       (AW)
    ) u_store (
        .i_clk     (i_clk),
        .i_k_we    (in_acc && cnt_open),
        .i_k_waddr (r_count[AW-1:0]),
        .i_k_wdata (i_in.payload.sample_a),
        .i_k_raddr (r_k[AW-1:0]),
        .o_k_rdata (k_rdata),
        .i_h_we    (in_acc),
        .i_h_waddr (n_head),
        .i_h_wdata (i_in.payload.sample_b),
        .i_h_raddr (r_hptr),
        .o_h_rdata (h_rdata)
    );

    // Multiply-accumulate.
    assign mac_ctl.clear    = in_acc;
    assign mac_ctl.data_vld = r_rd_vld;

    trcv_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (mac_ctl),
        .i_k_smp (k_rdata),
        .i_h_smp (h_rdata),
        .o_acc   (acc),
        .o_stat  (mac_stat)
    );

    // Checks.
    a_run_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN) |-> (r_k < r_terms))
        else $error("term index beyond term count");

    a_done_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) |-> (!r_rd_vld && !mac_stat.pending))
        else $error("result taken while products still in flight");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && cnt_open) |=> (r_count == CW'($past(r_count) + 1'b1)))
        else $error("sample count did not advance");

    a_terms_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_terms <= CW'(MAX_TAPS)) && (r_count <= CW'(MAX_TAPS)))
        else $error("term count above tap limit");

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the truncated running convolution core. A local
// predictor keeps its own copy of the stored A taps, the B history ring and
// the sample count. It computes every expected saturated sum as each input
// transaction is accepted. Directed items cover the sample extremes and the
// depth corner values. Random phases then run well past the point where the
// tap store freezes, under three handshake idling profiles.
// ----------------------------------------------------------------------------
module testbench;
    import trcv_pkg::*;

    localparam int MAX_TAPS    = 256;
    localparam int STALL_LIMIT = 4000;
    localparam int TAIL_CYCLES = 300;
    localparam int PHASE_ITEMS = 50;
    localparam int MAX_PRINTS  = 100;

    logic i_clk = 1'b0;
    logic i_rst_n;

    trcv_stream_if #(.t_payload(t_in_item))  in_if ();
    trcv_stream_if #(.t_payload(t_out_item)) out_if ();
    trcv_stream_if #(.t_payload(t_cfg_item)) cfg_if ();

    truncated_running_convolution_core #(
        .MAX_TAPS(MAX_TAPS)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    // Predictor state: stored A taps, B history ring, count and depth.
    t_sample          tap_store [MAX_TAPS];
    t_sample          b_history [MAX_TAPS];
    int unsigned      taken_count;
    int unsigned      ring_pos;
    logic [CFG_W-1:0] depth_reg;

    t_acc conv_expect_q [$];
    int   err_count;
    int   src_idle_pct;
    int   sink_idle_pct;
    int   stall_cycles = 0;

    // Free-running clock, 4 ns period.
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Log one mismatch and count it.
    task automatic report_mismatch(string msg);
        err_count++;
        if (err_count <= MAX_PRINTS) begin
            $display("[%0t] MISMATCH: %s", $realtime, msg);
        end
    endtask

    // Advance the predictor by one sample pair and return the expected sum.
    function automatic t_acc next_conv_sum(t_sample a, t_sample b);
        int unsigned limit;
        int unsigned avail;
        int unsigned terms;
        int unsigned idx;
        int unsigned k;
        longint      acc;
        if (depth_reg > MAX_TAPS) begin
            limit = MAX_TAPS;
        end else begin
            limit = depth_reg;
        end
        if (taken_count < MAX_TAPS) begin
            tap_store[taken_count] = a;
        end
        ring_pos = (ring_pos + 1) % MAX_TAPS;
        b_history[ring_pos] = b;
        avail = (taken_count < MAX_TAPS) ? taken_count + 1 : MAX_TAPS;
        terms = (avail < limit) ? avail : limit;
        acc = 0;
        // Saturate after every added term, as the hardware accumulator does.
        for (k = 0; k < terms; k++) begin
            idx = (ring_pos + MAX_TAPS - k) % MAX_TAPS;
            acc += longint'(tap_store[k]) * longint'(b_history[idx]);
            if (acc > longint'(ACC_MAX)) begin
                acc = longint'(ACC_MAX);
            end
            if (acc < longint'(ACC_MIN)) begin
                acc = longint'(ACC_MIN);
            end
        end
        if (taken_count < MAX_TAPS) begin
            taken_count++;
        end
        return t_acc'(acc);
    endfunction

    // Send one sample pair, with random idle cycles ahead of it.
    task automatic send_samples(t_sample a, t_sample b);
        t_in_item item;
        t_acc     exp_sum;
        item.sample_a = a;
        item.sample_b = b;
        while ($urandom_range(99) < src_idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid   <= 1'b1;
        in_if.payload <= item;
        @(posedge i_clk);
        while (!in_if.ready) begin
            @(posedge i_clk);
        end
        exp_sum = next_conv_sum(a, b);
        conv_expect_q.insert(conv_expect_q.size(), exp_sum);
    endtask

    // Hold the input off until every expected sum has come back.
    task automatic wait_idle();
        in_if.valid <= 1'b0;
        while (conv_expect_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (8) @(posedge i_clk);
    endtask

    // Write the truncation depth register; called only while idle.
    task automatic write_depth(logic [CFG_W-1:0] depth);
        cfg_if.valid                    <= 1'b1;
        cfg_if.payload.truncation_depth <= depth;
        @(posedge i_clk);
        while (!cfg_if.ready) begin
            @(posedge i_clk);
        end
        depth_reg = depth;
        cfg_if.valid <= 1'b0;
    endtask

    // Random sample with the two extremes drawn more often.
    function automatic t_sample rand_sample();
        case ($urandom_range(7))
            0:       return 16'sh8000;
            1:       return 16'sh7fff;
            default: return t_sample'($urandom_range(0, 65535));
        endcase
    endfunction

    // Sample extremes at the reset depth; these also fill the first taps.
    task automatic test_sample_extremes();
        send_samples(16'sh8000, 16'sh8000);
        send_samples(16'sh7fff, 16'sh7fff);
        send_samples(16'sh8000, 16'sh7fff);
        send_samples(16'sh7fff, 16'sh8000);
        send_samples(16'sh0000, 16'sh0000);
        send_samples(16'shffff, 16'sh0001);
        send_samples(16'sh0001, 16'shffff);
        send_samples(16'sh8000, 16'sh8000);
        send_samples(16'sh5555, 16'shaaaa);
        send_samples(16'shaaaa, 16'sh5555);
        send_samples(16'sh7fff, 16'sh8000);
        send_samples(16'sh8000, 16'sh8000);
        send_samples(16'sh8000, 16'sh7fff);
        send_samples(16'sh0000, 16'sh8000);
    endtask

    // Depth zero gives a zero sum, depth one uses a single term, and a
    // depth above the tap count behaves as the full tap count.
    task automatic test_depth_corners();
        wait_idle();
        write_depth(9'd0);
        send_samples(16'sh7fff, 16'sh7fff);
        send_samples(16'sh8000, 16'sh8000);
        wait_idle();
        write_depth(9'd1);
        send_samples(16'sh8000, 16'sh8000);
        send_samples(16'sh1234, 16'sh7fff);
        wait_idle();
        write_depth(9'd511);
        send_samples(16'sh8000, 16'sh8000);
        send_samples(16'sh7fff, 16'sh8000);
        wait_idle();
        write_depth(9'd256);
        send_samples(16'sh8000, 16'sh7fff);
        send_samples(16'sh7fff, 16'sh7fff);
    endtask

    // Random phases under three idling profiles; the stream runs long enough
    // for the tap store to freeze while the history keeps moving.
    task automatic test_random_stream();
        logic [CFG_W-1:0] depth;
        int               profile;
        int               phase;
        int               n;
        for (profile = 0; profile < 3; profile++) begin
            case (profile)
                0: begin
                    src_idle_pct  = 20;
                    sink_idle_pct = 67;
                end
                1: begin
                    src_idle_pct  = 67;
                    sink_idle_pct = 20;
                end
                default: begin
                    src_idle_pct  = 0;
                    sink_idle_pct = 0;
                end
            endcase
            for (phase = 0; phase < 3; phase++) begin
                case ($urandom_range(7))
                    0:       depth = 9'd0;
                    1:       depth = 9'd1;
                    2:       depth = 9'd256;
                    3:       depth = 9'($urandom_range(257, 511));
                    default: depth = 9'($urandom_range(2, 255));
                endcase
                wait_idle();
                write_depth(depth);
                for (n = 0; n < PHASE_ITEMS; n++) begin
                    send_samples(rand_sample(), rand_sample());
                end
            end
        end
    endtask

    // Result checker and random backpressure on the output channel.
    always @(posedge i_clk) begin : result_check
        t_acc want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (conv_expect_q.size() == 0) begin
                report_mismatch($sformatf("unexpected conv_sum %0d",
                                          out_if.payload.conv_sum));
            end else begin
                want = conv_expect_q.pop_front();
                if (out_if.payload.conv_sum !== want) begin
                    report_mismatch($sformatf("conv_sum %0d, expected %0d",
                                              out_if.payload.conv_sum, want));
                end
            end
        end
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    // Watchdog on cycles in which no transaction completes on any channel.
    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
            (cfg_if.valid && cfg_if.ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("Timeout after %0d idle cycles", stall_cycles);
            $display("*** FAILED ***");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // Reset, run the tests in turn, drain and give the verdict.
    initial begin
        err_count     = 0;
        taken_count   = 0;
        ring_pos      = 0;
        depth_reg     = DEPTH_RST;
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        i_rst_n        <= 1'b0;
        in_if.valid    <= 1'b0;
        in_if.payload  <= '0;
        cfg_if.valid   <= 1'b0;
        cfg_if.payload <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_sample_extremes();
        test_depth_corners();
        test_random_stream();

        wait_idle();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (err_count == 0 && conv_expect_q.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
